### src/tfce_pkg.sv
// Package for the flow completion time estimator.
// Holds the sequencer state and log-mode types and the field widths.
// No dependencies.
package tfce_pkg;

  localparam logic [30:0] INF_SSTHRESH = 31'h7FFF_FFFF;
  localparam logic [9:0]  ROUNDS_MAX   = 10'h3FF;
  localparam logic [33:0] TIME_MAX     = 34'h3_FFFF_FFFF;
  localparam int          DIV_BITS     = 17;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FREE,
    S_FIT,
    S_CLASS,
    S_SHIFT,
    S_SPLIT,
    S_POW,
    S_NP,
    S_NPE0,
    S_NPE,
    S_DRAIN,
    S_DIV,
    S_CEIL,
    S_BITLEN,
    S_LOG,
    S_MUL,
    S_ADD
  } state_t;

  // What the divide / bit-length pass feeds:
  // LOG_CEIL  -> rounds = floor(log2(ceil(q/w)))
  // LOG_FLOOR -> rounds-to-go = bitlen(q/w) plus one, minus one when exact
  typedef enum logic {
    LOG_CEIL,
    LOG_FLOOR
  } log_mode_t;

endpackage

### src/tcp_flow_completion_time_estimator_core.sv
// Flow completion time estimator, top level.
// Depends on tfce_pkg (types, widths, threshold constant).
//
//  channel  | ports                                                  | beat
//  ---------+--------------------------------------------------------+-------------------
//  command  | start, busy, unsent_packets, packets_in_flight,        | start & !busy
//           | congestion_window, slow_start_threshold,               |
//           | round_trip_time                                        |
//  result   | done, rounds, completion_time                          | done (one cycle)
//
// Paths: when the queue fits the free window, busy covers S_FREE, S_FIT, S_MUL and S_ADD.
// The log path adds the threshold shift search (S_SHIFT), the bit-serial divide (S_DIV) and
// the bit-length count (S_BITLEN). Congestion avoidance steps through the linear rounds in
// S_DRAIN. All work runs one datapath step per cycle, mostly subtracts, compares and shifts,
// with one multiply and one add at the end.
// busy rises in the cycle after the beat and falls in the cycle the result strobe rises.
// Reset (rst, synchronous) returns the sequencer to idle and drops done.
// The receiver cannot stall: done is high for exactly one cycle per command.
module tcp_flow_completion_time_estimator_core
  import tfce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] unsent_packets,
  input  logic [15:0] packets_in_flight,
  input  logic [15:0] congestion_window,
  input  logic [30:0] slow_start_threshold,
  input  logic [23:0] round_trip_time,
  output logic        done,
  output logic [9:0]  rounds,
  output logic [33:0] completion_time
);

  state_t      state, state_next;
  log_mode_t   mode;

  logic [16:0] q;     // packets still to send
  logic [31:0] w;     // working window
  logic [30:0] thr;
  logic [23:0] rtt;
  logic [31:0] m;     // window shifted toward the threshold
  logic [4:0]  j;     // shift count
  logic [31:0] acc;   // scratch: free window, ss, low, e, log operand
  logic [9:0]  n;     // rtt multiples in the time
  logic [9:0]  r;     // reported rounds
  logic [16:0] quo;
  logic [16:0] rem;
  logic [4:0]  cnt;
  logic [4:0]  bl;
  logic [33:0] prod;

  // shared compare / subtract terms
  logic        q_le_acc, q_eq_acc, q_le_w, m_lt_thr, m_eq_thr, w_le_thr;
  logic [31:0] q_minus_acc;
  logic [17:0] rem_sh;
  logic        div_bit;
  logic [34:0] sum;

  assign q_le_acc    = {15'd0, q} <= acc;
  assign q_eq_acc    = {15'd0, q} == acc;
  assign q_le_w      = {15'd0, q} <= w;
  assign m_lt_thr    = m < {1'b0, thr};
  assign m_eq_thr    = m == {1'b0, thr};
  assign w_le_thr    = w <= {1'b0, thr};
  assign q_minus_acc = {15'd0, q} - acc;
  assign rem_sh      = {rem, quo[16]};
  assign div_bit     = rem_sh >= {1'b0, w[16:0]};
  assign sum         = {1'b0, prod} + {12'd0, rtt[23:1]};

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_FREE;
      S_FREE:   state_next = S_FIT;
      S_FIT:    state_next = q_le_acc ? S_MUL : S_CLASS;
      S_CLASS: begin
        if (thr == INF_SSTHRESH) state_next = q_le_w ? S_MUL : S_DIV;
        else if (!w_le_thr)      state_next = S_DRAIN;
        else                     state_next = S_SHIFT;
      end
      S_SHIFT:  if (!m_lt_thr) state_next = S_SPLIT;
      S_SPLIT: begin
        if (m_eq_thr)    state_next = S_POW;
        else if (q_le_w) state_next = S_MUL;
        else             state_next = S_NP;
      end
      S_POW: begin
        if (!q_le_acc)   state_next = S_DRAIN;
        else if (q_le_w) state_next = S_MUL;
        else             state_next = S_DIV;
      end
      S_NP: begin
        if (q_eq_acc)      state_next = S_MUL;
        else if (q_le_acc) state_next = S_DIV;
        else               state_next = S_NPE0;
      end
      S_NPE0:   state_next = S_NPE;
      S_NPE:    state_next = q_le_acc ? S_MUL : S_DRAIN;
      S_DRAIN:  if (q == '0) state_next = S_MUL;
      S_DIV:    if (cnt == 5'(DIV_BITS - 1)) state_next = S_CEIL;
      S_CEIL:   state_next = S_BITLEN;
      S_BITLEN: if (acc == '0) state_next = S_LOG;
      S_LOG:    state_next = S_MUL;
      S_MUL:    state_next = S_ADD;
      S_ADD:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= state == S_ADD;
    end
  end

  // datapath, one step per state
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          q   <= {1'b0, unsent_packets} + 17'd1;
          w   <= (congestion_window == '0) ? 32'd1 : {16'd0, congestion_window};
          acc <= {16'd0, packets_in_flight};
          thr <= slow_start_threshold;
          rtt <= round_trip_time;
          n   <= '0;
          r   <= '0;
        end
      end
      S_FREE: acc <= (w > acc) ? w - acc : '0;
      S_FIT: begin
        if (!q_le_acc) begin
          q <= q_minus_acc[16:0];
          w <= w_le_thr ? {w[30:0], 1'b0} : w + 32'd1;
        end
      end
      S_CLASS: begin
        // infinite threshold: doubling all the way
        if (thr == INF_SSTHRESH) begin
          if (q_le_w) n <= 10'd1;
          mode <= LOG_CEIL;
          rem  <= '0;
          quo  <= q;
          cnt  <= '0;
        end
        m <= w;
        j <= '0;
      end
      S_SHIFT: begin
        if (m_lt_thr) begin
          m <= {m[30:0], 1'b0};
          j <= j + 5'd1;
        end
      end
      S_SPLIT: begin
        if (m_eq_thr) acc <= {thr, 1'b0} - w;   // slow-start capacity
        else begin
          if (q_le_w) n <= 10'd1;
          acc <= m - w;                          // low bound of the last doubling
        end
      end
      S_POW: begin
        if (!q_le_acc) begin
          q <= q_minus_acc[16:0];
          w <= {1'b0, thr} + 32'd1;
          n <= {5'd0, j} + 10'd1;
          r <= {5'd0, j} + 10'd1;
        end else if (q_le_w) begin
          n <= 10'd1;
        end else begin
          mode <= LOG_CEIL;
          rem  <= '0;
          quo  <= q;
          cnt  <= '0;
        end
      end
      S_NP: begin
        if (q_eq_acc) begin
          n <= {5'd0, j};
        end else if (q_le_acc) begin
          mode <= LOG_FLOOR;
          rem  <= '0;
          quo  <= q;
          cnt  <= '0;
        end else begin
          q <= q_minus_acc[16:0];
        end
      end
      S_NPE0: acc <= {thr, 1'b0} - m;            // room between last doubling and threshold
      S_NPE: begin
        if (q_le_acc) begin
          n <= {5'd0, j} + 10'd1;
        end else begin
          q <= q_minus_acc[16:0];
          w <= {1'b0, thr} + 32'd1;
          n <= {5'd0, j};
        end
      end
      S_DRAIN: begin
        if (q != '0) begin
          q <= ({15'd0, q} > w) ? q - w[16:0] : '0;
          w <= w + 32'd1;
          if (n != ROUNDS_MAX) n <= n + 10'd1;
          if (r != ROUNDS_MAX) r <= r + 10'd1;
        end
      end
      S_DIV: begin
        quo <= {quo[15:0], div_bit};
        rem <= div_bit ? 17'(rem_sh - {1'b0, w[16:0]}) : rem_sh[16:0];
        cnt <= cnt + 5'd1;
      end
      S_CEIL: begin
        if (mode == LOG_CEIL) acc <= {15'd0, quo} + {31'd0, rem != '0};
        else                  acc <= {15'd0, quo};
        bl <= '0;
      end
      S_BITLEN: begin
        if (acc != '0) begin
          acc <= {1'b0, acc[31:1]};
          bl  <= bl + 5'd1;
        end
      end
      S_LOG: begin
        if (mode == LOG_CEIL) begin
          r <= {5'd0, bl} - 10'd1;
          n <= {5'd0, bl};
        end else begin
          r <= '0;
          n <= {5'd0, bl} + 10'd1 - {9'd0, rem == '0};
        end
      end
      S_MUL: prod <= {10'd0, rtt} * {24'd0, n};
      S_ADD: begin
        completion_time <= sum[34] ? TIME_MAX : sum[33:0];
        rounds          <= r;
      end
      default: ;
    endcase
  end

endmodule

### src/tfce_checker.sv
// Port-level checker for the flow completion time estimator.
// Depends on tcp_flow_completion_time_estimator_core (bound below).
module tfce_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_beat_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after beat");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy)) else $error("result without work");

  a_end_done: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done) else $error("work ended with no result");

endmodule

bind tcp_flow_completion_time_estimator_core tfce_checker u_tfce_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done)
);
